/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the deframer rtl, clocked on clk_i with reset
// rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// pfd_pkg
// Types and constants of the frame deframer
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POP_W  = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POP_W-1:0]  pop_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_DEST    = 3'd2,
    PH_ORIG    = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  // number of set bits in one byte
  function automatic pop_t ones_in(input byte_t v);
    pop_t n;
    n = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      n = n + pop_t'(v[b]);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/pfd_rx_if.sv */
// ----------------------------------------------------------------------------
// pfd_rx_if
// Received byte channel: one frame byte and its start-of-frame flag
// ----------------------------------------------------------------------------
interface pfd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [pfd_pkg::BYTE_W-1:0] rx_byte;
  logic                       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

/* hw/rtl/pfd_res_if.sv */
// ----------------------------------------------------------------------------
// pfd_res_if
// Result channel: forwarded payload byte or end-of-frame summary
// ----------------------------------------------------------------------------
interface pfd_res_if;
  logic                       valid;
  logic                       ready;
  logic [pfd_pkg::BYTE_W-1:0] out_byte;
  logic                       last;
  logic                       checksum_ok;
  logic [pfd_pkg::BYTE_W-1:0] dest_addr;
  logic [pfd_pkg::BYTE_W-1:0] orig_addr;
  logic [pfd_pkg::BYTE_W-1:0] pay_length;

  modport source (output valid, output out_byte, output last, output checksum_ok,
                  output dest_addr, output orig_addr, output pay_length, input ready);
  modport sink   (input valid, input out_byte, input last, input checksum_ok,
                  input dest_addr, input orig_addr, input pay_length, output ready);
endinterface

/* hw/rtl/popcount_frame_deframer.sv */
// ----------------------------------------------------------------------------
// popcount_frame_deframer
// Strips the header of received frames, forwards payload bytes and checks a
// set-bit-count checksum
// ----------------------------------------------------------------------------
// Every received word is taken into an input register and handled by one pass
// of parsing logic that writes the result register, so one word is accepted
// per clock when the result side is not stalled, while a stalled result
// register holds back the input register. A word marked frame_start
// restarts parsing; HEADER_BYTES header words are skipped, then destination,
// origin and length are latched. Each payload word is forwarded with last low,
// and the trailing checksum word yields one summary with last high and
// checksum_ok set when it equals the set-bit count (mod 256) of destination,
// origin, length and payload. A frame cut by a new frame_start gives no
// summary; words outside a frame are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module popcount_frame_deframer #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfd_rx_if.sink      rx_i,
  pfd_res_if.source   res_o
);
  import pfd_pkg::*;

  localparam int unsigned HCW = $clog2(HEADER_BYTES + 1);
  localparam logic [HCW-1:0] HDR_LAST = HCW'(HEADER_BYTES);

  // input register
  logic   in_vld_q;
  byte_t  in_byte_q;
  logic   in_start_q;

  // parser state
  phase_e          phase_q, phase_d;
  logic [HCW-1:0]  hdr_cnt_q, hdr_cnt_d;
  byte_t           pay_cnt_q, pay_cnt_d;
  byte_t           dest_q, dest_d;
  byte_t           orig_q, orig_d;
  byte_t           len_q, len_d;
  byte_t           sum_q, sum_d;

  // result register
  logic   res_vld_q;
  byte_t  res_byte_q, res_byte_d;
  logic   res_last_q, res_last_d;
  logic   res_ok_q, res_ok_d;
  byte_t  res_dest_q, res_orig_q, res_len_q;
  logic   emit;

  logic   res_free;
  logic   proc;
  logic   in_take;
  byte_t  sum_add;

  assign res_free = !res_vld_q || res_o.ready;
  assign proc     = in_vld_q && res_free;
  assign rx_i.ready = !in_vld_q || res_free;
  assign in_take  = rx_i.valid && rx_i.ready;
  assign sum_add  = sum_q + byte_t'(ones_in(in_byte_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= rx_i.rx_byte;
      in_start_q <= rx_i.frame_start;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    pay_cnt_d  = pay_cnt_q;
    dest_d     = dest_q;
    orig_d     = orig_q;
    len_d      = len_q;
    sum_d      = sum_q;
    emit       = 1'b0;
    res_byte_d = in_byte_q;
    res_last_d = 1'b0;
    res_ok_d   = 1'b0;
    if (in_start_q) begin
      sum_d     = '0;
      hdr_cnt_d = HCW'(1);
      phase_d   = (HEADER_BYTES <= 1) ? PH_DEST : PH_HEADER;
    end else begin
      case (phase_q)
        PH_HEADER: begin
          hdr_cnt_d = hdr_cnt_q + HCW'(1);
          if (hdr_cnt_d >= HDR_LAST) begin
            phase_d = PH_DEST;
          end
        end
        PH_DEST: begin
          dest_d  = in_byte_q;
          sum_d   = sum_add;
          phase_d = PH_ORIG;
        end
        PH_ORIG: begin
          orig_d  = in_byte_q;
          sum_d   = sum_add;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d     = in_byte_q;
          sum_d     = sum_add;
          pay_cnt_d = '0;
          phase_d   = (in_byte_q == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_d     = sum_add;
          pay_cnt_d = pay_cnt_q + byte_t'(1);
          if (pay_cnt_d == len_q) begin
            phase_d = PH_CHECK;
          end
          emit = 1'b1;
        end
        PH_CHECK: begin
          phase_d    = PH_IDLE;
          emit       = 1'b1;
          res_byte_d = '0;
          res_last_d = 1'b1;
          res_ok_d   = (in_byte_q == sum_q);
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hdr_cnt_q <= '0;
      pay_cnt_q <= '0;
      dest_q    <= '0;
      orig_q    <= '0;
      len_q     <= '0;
      sum_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (proc) begin
        phase_q   <= phase_d;
        hdr_cnt_q <= hdr_cnt_d;
        pay_cnt_q <= pay_cnt_d;
        dest_q    <= dest_d;
        orig_q    <= orig_d;
        len_q     <= len_d;
        sum_q     <= sum_d;
      end
      if (res_free) begin
        res_vld_q <= proc && emit;
      end
    end
  end

  // summary carries the holds as they stand when the word is handled
  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      res_byte_q <= res_byte_d;
      res_last_q <= res_last_d;
      res_ok_q   <= res_ok_d;
      res_dest_q <= dest_q;
      res_orig_q <= orig_q;
      res_len_q  <= len_q;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.out_byte    = res_byte_q;
  assign res_o.last        = res_last_q;
  assign res_o.checksum_ok = res_ok_q;
  assign res_o.dest_addr   = res_dest_q;
  assign res_o.orig_addr   = res_orig_q;
  assign res_o.pay_length  = res_len_q;

  `PFD_ASSERT(a_ok_only_on_last, res_vld_q && !res_last_q, !res_ok_q)
  `PFD_ASSERT_NEXT(a_start_clears_sum, proc && in_start_q,
                   sum_q == '0 && (phase_q == PH_HEADER || phase_q == PH_DEST))
  `PFD_ASSERT_NEXT(a_check_gives_last, proc && !in_start_q && phase_q == PH_CHECK,
                   res_vld_q && res_last_q && phase_q == PH_IDLE)

endmodule
